### rtl/dfod_pkg.sv
`timescale 1ns / 1ps

package dfod_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic [12:0] ROW_PITCH_RESET = 13'd320;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] position;
    logic [19:0] address;
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [16:0] pair_count;
    logic        frame_done;
  } out_t;

  // Decoded command handed from the parser to the address pipeline.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] position;
    logic [7:0]  pixel_a;
    logic [7:0]  pixel_b;
    logic [16:0] pair_count;
    logic        frame_done;
  } cmd_t;

endpackage

### rtl/dfod_front.sv
`timescale 1ns / 1ps

module dfod_front import dfod_pkg::*; #(
  parameter int FRAME_PIXELS = 64000
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  in_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_CNT_LO  = 3'd1;
  localparam logic [2:0] PH_CNT_HI  = 3'd2;
  localparam logic [2:0] PH_LITERAL = 3'd3;
  localparam logic [2:0] PH_PAT_A   = 3'd4;
  localparam logic [2:0] PH_PAT_B   = 3'd5;

  localparam logic [2:0] CL_SKIP8  = 3'd0;
  localparam logic [2:0] CL_SKIP16 = 3'd1;
  localparam logic [2:0] CL_LIT8   = 3'd2;
  localparam logic [2:0] CL_LIT16  = 3'd3;
  localparam logic [2:0] CL_PAT8   = 3'd4;
  localparam logic [2:0] CL_PAT16  = 3'd5;

  localparam logic [7:0] OP_END       = 8'h00;
  localparam logic [7:0] OP_END_ALT   = 8'h13;
  localparam logic [7:0] OP_SKIP1     = 8'h02;
  localparam logic [7:0] OP_SKIP8     = 8'h03;
  localparam logic [7:0] OP_SKIP16    = 8'h04;
  localparam logic [7:0] OP_LIT_FIRST = 8'h06;
  localparam logic [7:0] OP_LIT_LAST  = 8'h0a;
  localparam logic [7:0] OP_LIT8      = 8'h0b;
  localparam logic [7:0] OP_LIT16     = 8'h0c;
  localparam logic [7:0] OP_PAT_FIRST = 8'h0d;
  localparam logic [7:0] OP_PAT_LAST  = 8'h10;
  localparam logic [7:0] OP_PAT8      = 8'h11;
  localparam logic [7:0] OP_PAT16     = 8'h12;
  localparam logic [7:0] LIT_BIAS     = 8'd5;
  localparam logic [7:0] PAT_BIAS     = 8'd11;

  localparam logic [16:0] FRAME_PIX = 17'(FRAME_PIXELS);

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  op_class_q, op_class_d;
  logic [16:0] pos_q, pos_d;
  logic [17:0] bytes_left_q, bytes_left_d;
  logic [7:0]  count_low_q, count_low_d;
  logic [7:0]  pattern_first_q, pattern_first_d;
  logic        frame_ended_q, frame_ended_d;

  logic [7:0]  d;
  logic [16:0] cnt_n;
  logic        start;
  logic [16:0] room;
  logic [17:0] pairs;
  logic [17:0] bl_next;
  logic        emit;
  cmd_t        cmd;

  function automatic logic [16:0] sat_advance(input logic [16:0] p, input logic [18:0] inc);
    logic [19:0] s;
    s = {3'd0, p} + {1'b0, inc};
    if (s > {3'd0, FRAME_PIX}) begin
      return FRAME_PIX;
    end
    return s[16:0];
  endfunction

  assign d = in_i.data_byte;

  always_comb begin
    phase_d         = phase_q;
    op_class_d      = op_class_q;
    pos_d           = pos_q;
    bytes_left_d    = bytes_left_q;
    count_low_d     = count_low_q;
    pattern_first_d = pattern_first_q;
    frame_ended_d   = frame_ended_q;
    emit            = 1'b0;
    cmd             = '0;
    cnt_n           = '0;
    start           = 1'b0;
    room            = '0;
    pairs           = '0;
    bl_next         = '0;

    if (accept_i) begin
      if (frame_ended_q) begin
        // After an end opcode the rest of the stream is dropped up to the last word.
        if (in_i.last_byte) begin
          frame_ended_d   = 1'b0;
          phase_d         = PH_OPCODE;
          op_class_d      = '0;
          pos_d           = '0;
          bytes_left_d    = '0;
          count_low_d     = '0;
          pattern_first_d = '0;
        end
      end else begin
        unique case (phase_q)
          PH_OPCODE: begin
            unique case (d) inside
              OP_END, OP_END_ALT: begin
                emit            = 1'b1;
                cmd.kind        = KIND_END;
                cmd.frame_done  = 1'b1;
                frame_ended_d   = !in_i.last_byte;
                phase_d         = PH_OPCODE;
                op_class_d      = '0;
                pos_d           = '0;
                bytes_left_d    = '0;
                count_low_d     = '0;
                pattern_first_d = '0;
              end
              OP_SKIP1: begin
                pos_d = sat_advance(pos_q, 19'd2);
              end
              OP_SKIP8, OP_SKIP16: begin
                op_class_d = (d == OP_SKIP8) ? CL_SKIP8 : CL_SKIP16;
                phase_d    = PH_CNT_LO;
              end
              [OP_LIT_FIRST:OP_LIT_LAST]: begin
                bytes_left_d = {9'd0, d - LIT_BIAS, 1'b0};
                phase_d      = PH_LITERAL;
              end
              OP_LIT8, OP_LIT16: begin
                op_class_d = (d == OP_LIT8) ? CL_LIT8 : CL_LIT16;
                phase_d    = PH_CNT_LO;
              end
              [OP_PAT_FIRST:OP_PAT_LAST]: begin
                bytes_left_d = {10'd0, d - PAT_BIAS};
                phase_d      = PH_PAT_A;
              end
              OP_PAT8, OP_PAT16: begin
                op_class_d = (d == OP_PAT8) ? CL_PAT8 : CL_PAT16;
                phase_d    = PH_CNT_LO;
              end
              default: begin
              end
            endcase
          end
          PH_CNT_LO: begin
            if (op_class_q == CL_SKIP8 || op_class_q == CL_LIT8 || op_class_q == CL_PAT8) begin
              cnt_n = {9'd0, d} + 17'd1;
              start = 1'b1;
            end else begin
              count_low_d = d;
              phase_d     = PH_CNT_HI;
            end
          end
          PH_CNT_HI: begin
            cnt_n = {1'b0, d, count_low_q} + 17'd1;
            start = 1'b1;
          end
          PH_LITERAL: begin
            if (pos_q < FRAME_PIX) begin
              emit          = 1'b1;
              cmd.kind      = KIND_PIXEL;
              cmd.position  = pos_q[15:0];
              cmd.pixel_a   = d;
            end
            pos_d   = sat_advance(pos_q, 19'd1);
            bl_next = bytes_left_q - {17'd0, bytes_left_q != 18'd0};
            bytes_left_d = bl_next;
            if (bl_next == 18'd0) begin
              phase_d = PH_OPCODE;
            end
          end
          PH_PAT_A: begin
            pattern_first_d = d;
            phase_d         = PH_PAT_B;
          end
          default: begin
            // Second pattern byte: clip the run to the whole pairs left in the frame.
            if (pos_q < FRAME_PIX) begin
              room = (FRAME_PIX - pos_q) >> 1;
            end
            pairs = (bytes_left_q < {1'b0, room}) ? bytes_left_q : {1'b0, room};
            if (pairs != 18'd0) begin
              emit           = 1'b1;
              cmd.kind       = KIND_RUN;
              cmd.position   = pos_q[15:0];
              cmd.pixel_a    = pattern_first_q;
              cmd.pixel_b    = d;
              cmd.pair_count = pairs[16:0];
            end
            pos_d        = sat_advance(pos_q, {bytes_left_q, 1'b0});
            bytes_left_d = '0;
            phase_d      = PH_OPCODE;
          end
        endcase

        if (start) begin
          if (op_class_q == CL_SKIP8 || op_class_q == CL_SKIP16) begin
            pos_d   = sat_advance(pos_q, {1'b0, cnt_n, 1'b0});
            phase_d = PH_OPCODE;
          end else if (op_class_q == CL_LIT8 || op_class_q == CL_LIT16) begin
            bytes_left_d = {cnt_n, 1'b0};
            phase_d      = PH_LITERAL;
          end else begin
            bytes_left_d = {1'b0, cnt_n};
            phase_d      = PH_PAT_A;
          end
        end

        // The last word closes the frame, with a bare end word if nothing else came out.
        if (in_i.last_byte) begin
          if (!emit) begin
            cmd      = '0;
            cmd.kind = KIND_END;
          end
          emit            = 1'b1;
          cmd.frame_done  = 1'b1;
          phase_d         = PH_OPCODE;
          op_class_d      = '0;
          pos_d           = '0;
          bytes_left_d    = '0;
          count_low_d     = '0;
          pattern_first_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_OPCODE;
      op_class_q      <= '0;
      pos_q           <= '0;
      bytes_left_q    <= '0;
      count_low_q     <= '0;
      pattern_first_q <= '0;
      frame_ended_q   <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      op_class_q      <= op_class_d;
      pos_q           <= pos_d;
      bytes_left_q    <= bytes_left_d;
      count_low_q     <= count_low_d;
      pattern_first_q <= pattern_first_d;
      frame_ended_q   <= frame_ended_d;
    end
  end

  assign cmd_valid_o = emit;
  assign cmd_o       = cmd;

endmodule

### rtl/dfod_queue.sv
`timescale 1ns / 1ps

module dfod_queue import dfod_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_FULL);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/dfod_back.sv
`timescale 1ns / 1ps

module dfod_back import dfod_pkg::*; #(
  parameter int LINE_WIDTH = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [12:0] row_pitch_i,
  input  logic        pop_i,
  output logic        empty_o,
  output out_t        out_o
);

  // Row is taken as (position * RECIP) >> SHIFT, exact for every 16-bit position.
  localparam int          SHIFT   = 16 + $clog2(LINE_WIDTH);
  localparam logic [63:0] RECIP64 =
      ((64'd1 << SHIFT) + 64'(LINE_WIDTH) - 64'd1) / 64'(LINE_WIDTH);
  localparam logic [16:0] RECIP   = RECIP64[16:0];
  localparam logic [15:0] LINE_W  = 16'(LINE_WIDTH);

  logic        adv;
  logic [47:0] recip_prod;
  logic [15:0] row_base;

  logic        s1_vld_q, s2_vld_q, s3_vld_q;
  cmd_t        s1_cmd_q, s2_cmd_q, s3_cmd_q;
  logic [15:0] s1_row_q;
  logic [15:0] s2_col_q;
  logic [19:0] s2_mul_q;
  logic [19:0] s3_addr_q;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv        = !s3_vld_q || pop_i;
  assign cmd_pop_o  = adv && cmd_valid_i;
  assign recip_prod = {32'd0, cmd_i.position} * {31'd0, RECIP};
  // Only the low 16 bits matter since the column is below the line width.
  assign row_base   = s1_row_q * LINE_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= cmd_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= cmd_i;
      s1_row_q  <= recip_prod[SHIFT +: 16];
      s2_cmd_q  <= s1_cmd_q;
      s2_col_q  <= s1_cmd_q.position - row_base;
      s2_mul_q  <= 20'({13'd0, s1_row_q} * {16'd0, row_pitch_i});
      s3_cmd_q  <= s2_cmd_q;
      s3_addr_q <= s2_mul_q + {4'd0, s2_col_q};
    end
  end

  assign empty_o          = !s3_vld_q;
  assign out_o.kind       = s3_cmd_q.kind;
  assign out_o.position   = s3_cmd_q.position;
  assign out_o.address    = (s3_cmd_q.kind == KIND_PIXEL) ? s3_addr_q : '0;
  assign out_o.pixel_a    = s3_cmd_q.pixel_a;
  assign out_o.pixel_b    = s3_cmd_q.pixel_b;
  assign out_o.pair_count = s3_cmd_q.pair_count;
  assign out_o.frame_done = s3_cmd_q.frame_done;

endmodule

### rtl/delta_frame_opcode_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// input     push / full         in_word_i   (data_byte, last_byte)
// result    empty / pop         out_word_o  (kind .. frame_done)
// config    cfg_we_i            cfg_wdata_i (row_pitch)
//
// One byte is taken per clock while full is low; the parser handles each byte in
// the cycle it arrives. A result goes from the command queue through the address
// pipeline registers s1, s2 and s3; the last holds the word until it is popped.
// Reset is asynchronous and active low; row_pitch resets to 320 and no clearing pass runs.
// A stalled pop holds the address pipeline; the parser runs on until the queue fills.

module delta_frame_opcode_decoder_top import dfod_pkg::*; #(
  parameter int LINE_WIDTH   = 320,
  parameter int FRAME_PIXELS = 64000,
  parameter int CMD_DEPTH    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_word_i,
  output logic        empty,
  input  logic        pop,
  output out_t        out_word_o,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i
);

  logic [12:0] row_pitch_q;
  logic        accept;
  logic        cmd_valid;
  cmd_t        cmd;
  cmd_t        q_data;
  logic        q_empty;
  logic        q_pop;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q <= ROW_PITCH_RESET;
    end else if (cfg_we_i) begin
      row_pitch_q <= cfg_wdata_i;
    end
  end

  dfod_front #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd)
  );

  dfod_queue #(
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_valid),
    .wr_data_i(cmd),
    .rd_en_i  (q_pop),
    .rd_data_o(q_data),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  dfod_back #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (q_data),
    .cmd_pop_o  (q_pop),
    .row_pitch_i(row_pitch_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_word_o)
  );

endmodule

### rtl/dfod_checker.sv
`timescale 1ns / 1ps

module dfod_checker import dfod_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input out_t out_word_o
);

  // A waiting word that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.kind == KIND_END |->
      out_word_o.frame_done && out_word_o.position == '0 && out_word_o.pair_count == '0)
    else $error("frame end word carries payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.kind == KIND_RUN |->
      out_word_o.pair_count != '0 && out_word_o.address == '0)
    else $error("run word with no pairs or an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.kind == KIND_PIXEL |->
      out_word_o.pair_count == '0 && out_word_o.pixel_b == '0)
    else $error("pixel word carries run fields");

endmodule

bind delta_frame_opcode_decoder_top dfod_checker u_dfod_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_word_o(out_word_o)
);
